[rtl/kml_pkg.sv]
package kml_pkg;

  // Field widths of the channel payloads
  localparam int COORD_W = 16;
  localparam int SLOT_W  = 2;
  localparam int COUNT_W = 24;
  localparam int CIDX_W  = 2;

  // Entries of the queue between classifier and accumulator
  localparam int QUEUE_DEPTH = 4;

  // Item kinds
  localparam logic KIND_SEED  = 1'b0;
  localparam logic KIND_POINT = 1'b1;

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [SLOT_W-1:0]  slot_t;
  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [CIDX_W-1:0]  cidx_t;

endpackage

[rtl/kml_if.sv]
interface kml_in_if;
  logic            valid;
  logic            ready;
  logic            kind;
  kml_pkg::coord_t point_x;
  kml_pkg::coord_t point_y;
  kml_pkg::slot_t  seed_slot;
  logic            last_point;

  modport source (
    output valid, kind, point_x, point_y, seed_slot, last_point,
    input  ready
  );
  modport sink (
    input  valid, kind, point_x, point_y, seed_slot, last_point,
    output ready
  );
endinterface

interface kml_out_if;
  logic            valid;
  logic            ready;
  kml_pkg::cidx_t  cluster_index;
  kml_pkg::coord_t mean_x;
  kml_pkg::coord_t mean_y;
  kml_pkg::count_t member_count;
  logic            any_changed;
  logic            was_empty;
  logic            last_cluster;

  modport source (
    output valid, cluster_index, mean_x, mean_y, member_count, any_changed,
           was_empty, last_cluster,
    input  ready
  );
  modport sink (
    input  valid, cluster_index, mean_x, mean_y, member_count, any_changed,
           was_empty, last_cluster,
    output ready
  );
endinterface

[rtl/kml_queue.sv]
module kml_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             push, pop;

  assign push_ready_o = (cnt_q != CNT_W'(DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

[rtl/kml_front.sv]
module kml_front #(
  parameter int CLUSTERS   = 4,
  parameter int COORD_BITS = 16,
  parameter int IDX_W      = 2,
  parameter int ENT_W      = 35
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  kml_in_if.sink                in_i,
  output logic                  push_valid_o,
  input  logic                  push_ready_i,
  output logic [ENT_W-1:0]      push_data_o,
  input  logic [IDX_W-1:0]      cen_idx_i,
  input  logic                  cen_we_i,
  input  logic [COORD_BITS-1:0] cen_x_i,
  input  logic [COORD_BITS-1:0] cen_y_i,
  input  logic                  upd_done_i,
  output logic [COORD_BITS-1:0] cen_x_o,
  output logic [COORD_BITS-1:0] cen_y_o
);

  localparam int SQ_W   = 2 * COORD_BITS;
  localparam int DIST_W = SQ_W + 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CLUSTERS - 1);

  typedef enum logic [1:0] {F_IDLE, F_SWEEP, F_PUSH} fstate_e;

  fstate_e f_state_q;

  logic [COORD_BITS-1:0] cx_q [CLUSTERS];
  logic [COORD_BITS-1:0] cy_q [CLUSTERS];

  logic                  pending_q;
  logic [IDX_W-1:0]      iss_q;
  logic                  iss_on_q;
  logic                  v1_q, v2_q;

  logic [COORD_BITS-1:0] px_q, py_q;
  logic                  last_q;
  logic [COORD_BITS-1:0] dx1_q, dy1_q;
  logic [IDX_W-1:0]      idx1_q, idx2_q;
  logic [SQ_W-1:0]       sqx2_q, sqy2_q;
  logic [DIST_W-1:0]     best_d_q;
  logic [IDX_W-1:0]      best_idx_q;

  logic [IDX_W-1:0]      rd_idx;
  logic [COORD_BITS-1:0] cur_x, cur_y, dx, dy;
  logic [SQ_W-1:0]       sqx, sqy;
  logic [DIST_W-1:0]     sq_sum;
  logic                  better;
  logic                  take, seed_ok;
  logic [IDX_W-1:0]      seed_idx;

  // While a pass update runs the accumulator owns the read port.
  assign rd_idx  = pending_q ? cen_idx_i : iss_q;
  assign cur_x   = cx_q[rd_idx];
  assign cur_y   = cy_q[rd_idx];
  assign cen_x_o = cur_x;
  assign cen_y_o = cur_y;

  assign in_i.ready = (f_state_q == F_IDLE) && !pending_q;
  assign take       = in_i.valid && in_i.ready;
  assign seed_ok    = 32'(in_i.seed_slot) < CLUSTERS;
  assign seed_idx   = IDX_W'(in_i.seed_slot);

  assign dx     = (cur_x >= px_q) ? cur_x - px_q : px_q - cur_x;
  assign dy     = (cur_y >= py_q) ? cur_y - py_q : py_q - cur_y;
  assign sqx    = SQ_W'(dx1_q) * SQ_W'(dx1_q);
  assign sqy    = SQ_W'(dy1_q) * SQ_W'(dy1_q);
  assign sq_sum = DIST_W'(sqx2_q) + DIST_W'(sqy2_q);
  // strict compare keeps the lower index on a tie
  assign better = (idx2_q == '0) || (sq_sum < best_d_q);

  assign push_valid_o = (f_state_q == F_PUSH);
  assign push_data_o  = {best_idx_q, px_q, py_q, last_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_state_q <= F_IDLE;
      pending_q <= 1'b0;
      iss_q     <= '0;
      iss_on_q  <= 1'b0;
      v1_q      <= 1'b0;
      v2_q      <= 1'b0;
      for (int k = 0; k < CLUSTERS; k++) begin
        cx_q[k] <= '0;
        cy_q[k] <= '0;
      end
    end else begin
      if (cen_we_i) begin
        cx_q[cen_idx_i] <= cen_x_i;
        cy_q[cen_idx_i] <= cen_y_i;
      end else if (take && in_i.kind == kml_pkg::KIND_SEED && seed_ok) begin
        cx_q[seed_idx] <= COORD_BITS'(in_i.point_x);
        cy_q[seed_idx] <= COORD_BITS'(in_i.point_y);
      end

      if (upd_done_i) begin
        pending_q <= 1'b0;
      end else if (push_valid_o && push_ready_i && last_q) begin
        pending_q <= 1'b1;
      end

      v1_q <= (f_state_q == F_SWEEP) && iss_on_q;
      v2_q <= v1_q;

      case (f_state_q)
        F_IDLE: begin
          if (take && in_i.kind == kml_pkg::KIND_POINT) begin
            f_state_q <= F_SWEEP;
            iss_q     <= '0;
            iss_on_q  <= 1'b1;
          end
        end
        F_SWEEP: begin
          if (iss_on_q) begin
            iss_q <= iss_q + IDX_W'(1);
            if (iss_q == LAST_IDX) begin
              iss_on_q <= 1'b0;
            end
          end
          if (v2_q && idx2_q == LAST_IDX) begin
            f_state_q <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (push_ready_i) begin
            f_state_q <= F_IDLE;
          end
        end
        default: begin
          f_state_q <= F_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      px_q   <= COORD_BITS'(in_i.point_x);
      py_q   <= COORD_BITS'(in_i.point_y);
      last_q <= in_i.last_point;
    end
    dx1_q  <= dx;
    dy1_q  <= dy;
    idx1_q <= iss_q;
    sqx2_q <= sqx;
    sqy2_q <= sqy;
    idx2_q <= idx1_q;
    if (v2_q && better) begin
      best_d_q   <= sq_sum;
      best_idx_q <= idx2_q;
    end
  end

endmodule

[rtl/kml_back.sv]
module kml_back #(
  parameter int CLUSTERS   = 4,
  parameter int COORD_BITS = 16,
  parameter int COUNT_BITS = 24,
  parameter int IDX_W      = 2,
  parameter int ENT_W      = 35
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  pop_valid_i,
  output logic                  pop_ready_o,
  input  logic [ENT_W-1:0]      pop_data_i,
  output logic [IDX_W-1:0]      cen_idx_o,
  output logic                  cen_we_o,
  output logic [COORD_BITS-1:0] cen_x_o,
  output logic [COORD_BITS-1:0] cen_y_o,
  output logic                  upd_done_o,
  input  logic [COORD_BITS-1:0] cen_x_i,
  input  logic [COORD_BITS-1:0] cen_y_i,
  kml_out_if.source             out_o
);

  localparam int SUM_W = COORD_BITS + COUNT_BITS;
  localparam int DV_W  = $clog2(COORD_BITS + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CLUSTERS - 1);

  typedef enum logic [2:0] {B_ACC, B_LOAD, B_DIV, B_FIN, B_EMIT} bstate_e;

  bstate_e b_state_q;

  logic [SUM_W-1:0]      tot_x_q [CLUSTERS];
  logic [SUM_W-1:0]      tot_y_q [CLUSTERS];
  logic [COUNT_BITS-1:0] tally_q [CLUSTERS];

  logic [COORD_BITS-1:0] res_x_q [CLUSTERS];
  logic [COORD_BITS-1:0] res_y_q [CLUSTERS];
  logic [COUNT_BITS-1:0] res_n_q [CLUSTERS];
  logic                  res_e_q [CLUSTERS];

  logic [IDX_W-1:0]      sw_q, em_q;
  logic [DV_W-1:0]       dv_cnt_q;
  logic                  changed_q;
  logic                  out_valid_q;

  logic [COUNT_BITS-1:0] remx_q, remy_q;
  logic [COORD_BITS-1:0] dqx_q, dqy_q;

  kml_pkg::cidx_t        o_idx_q;
  kml_pkg::coord_t       o_x_q, o_y_q;
  kml_pkg::count_t       o_n_q;
  logic                  o_chg_q, o_emp_q, o_last_q;

  logic [IDX_W-1:0]      e_idx;
  logic [COORD_BITS-1:0] e_px, e_py;
  logic                  e_last;
  logic                  pop, emit_load, not_full, sw_last, em_last;
  logic [IDX_W-1:0]      acc_idx;
  logic [COUNT_BITS-1:0] cur_tally;
  logic [SUM_W-1:0]      cur_tx, cur_ty;
  logic [COUNT_BITS:0]   shx, shy, subx, suby;
  logic                  gex, gey;

  assign {e_idx, e_px, e_py, e_last} = pop_data_i;

  assign pop_ready_o = (b_state_q == B_ACC);
  assign pop         = pop_valid_i && pop_ready_o;

  assign acc_idx   = (b_state_q == B_ACC) ? e_idx : sw_q;
  assign cur_tally = tally_q[acc_idx];
  assign cur_tx    = tot_x_q[acc_idx];
  assign cur_ty    = tot_y_q[acc_idx];
  assign not_full  = (cur_tally != '1);
  assign sw_last   = (sw_q == LAST_IDX);
  assign em_last   = (em_q == LAST_IDX);

  // Restoring divide, one quotient bit per cycle; the upper part of the sum
  // is already below the count because the mean fits the coordinate range.
  assign shx  = {remx_q, dqx_q[COORD_BITS-1]};
  assign shy  = {remy_q, dqy_q[COORD_BITS-1]};
  assign subx = shx - {1'b0, cur_tally};
  assign suby = shy - {1'b0, cur_tally};
  assign gex  = (shx >= {1'b0, cur_tally});
  assign gey  = (shy >= {1'b0, cur_tally});

  assign cen_idx_o  = sw_q;
  assign cen_we_o   = (b_state_q == B_FIN);
  assign cen_x_o    = dqx_q;
  assign cen_y_o    = dqy_q;
  assign upd_done_o = (b_state_q == B_FIN) && sw_last;

  assign emit_load = (b_state_q == B_EMIT) && (!out_valid_q || out_o.ready);

  assign out_o.valid         = out_valid_q;
  assign out_o.cluster_index = o_idx_q;
  assign out_o.mean_x        = o_x_q;
  assign out_o.mean_y        = o_y_q;
  assign out_o.member_count  = o_n_q;
  assign out_o.any_changed   = o_chg_q;
  assign out_o.was_empty     = o_emp_q;
  assign out_o.last_cluster  = o_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_state_q   <= B_ACC;
      sw_q        <= '0;
      em_q        <= '0;
      dv_cnt_q    <= '0;
      changed_q   <= 1'b0;
      out_valid_q <= 1'b0;
      for (int k = 0; k < CLUSTERS; k++) begin
        tot_x_q[k] <= '0;
        tot_y_q[k] <= '0;
        tally_q[k] <= '0;
      end
    end else begin
      if (emit_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end

      case (b_state_q)
        B_ACC: begin
          if (pop) begin
            // drop the point once its cluster count is saturated
            if (not_full) begin
              tally_q[e_idx] <= cur_tally + COUNT_BITS'(1);
              tot_x_q[e_idx] <= cur_tx + SUM_W'(e_px);
              tot_y_q[e_idx] <= cur_ty + SUM_W'(e_py);
            end
            if (e_last) begin
              b_state_q <= B_LOAD;
              sw_q      <= '0;
              changed_q <= 1'b0;
            end
          end
        end
        B_LOAD: begin
          if (cur_tally == '0) begin
            b_state_q <= B_FIN;
          end else begin
            b_state_q <= B_DIV;
            dv_cnt_q  <= DV_W'(COORD_BITS);
          end
        end
        B_DIV: begin
          dv_cnt_q <= dv_cnt_q - DV_W'(1);
          if (dv_cnt_q == DV_W'(1)) begin
            b_state_q <= B_FIN;
          end
        end
        B_FIN: begin
          if (dqx_q != cen_x_i || dqy_q != cen_y_i) begin
            changed_q <= 1'b1;
          end
          tally_q[sw_q] <= '0;
          tot_x_q[sw_q] <= '0;
          tot_y_q[sw_q] <= '0;
          if (sw_last) begin
            b_state_q <= B_EMIT;
            em_q      <= '0;
          end else begin
            b_state_q <= B_LOAD;
            sw_q      <= sw_q + IDX_W'(1);
          end
        end
        B_EMIT: begin
          if (emit_load) begin
            if (em_last) begin
              b_state_q <= B_ACC;
            end else begin
              em_q <= em_q + IDX_W'(1);
            end
          end
        end
        default: begin
          b_state_q <= B_ACC;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_state_q == B_LOAD) begin
      if (cur_tally == '0) begin
        // empty cluster keeps its centroid
        dqx_q <= cen_x_i;
        dqy_q <= cen_y_i;
      end else begin
        remx_q <= cur_tx[SUM_W-1:COORD_BITS];
        remy_q <= cur_ty[SUM_W-1:COORD_BITS];
        dqx_q  <= cur_tx[COORD_BITS-1:0];
        dqy_q  <= cur_ty[COORD_BITS-1:0];
      end
    end else if (b_state_q == B_DIV) begin
      remx_q <= gex ? subx[COUNT_BITS-1:0] : shx[COUNT_BITS-1:0];
      remy_q <= gey ? suby[COUNT_BITS-1:0] : shy[COUNT_BITS-1:0];
      dqx_q  <= {dqx_q[COORD_BITS-2:0], gex};
      dqy_q  <= {dqy_q[COORD_BITS-2:0], gey};
    end else if (b_state_q == B_FIN) begin
      res_x_q[sw_q] <= dqx_q;
      res_y_q[sw_q] <= dqy_q;
      res_n_q[sw_q] <= cur_tally;
      res_e_q[sw_q] <= (cur_tally == '0);
    end

    if (emit_load) begin
      o_idx_q  <= kml_pkg::cidx_t'(em_q);
      o_x_q    <= kml_pkg::coord_t'(res_x_q[em_q]);
      o_y_q    <= kml_pkg::coord_t'(res_y_q[em_q]);
      o_n_q    <= kml_pkg::count_t'(res_n_q[em_q]);
      o_chg_q  <= changed_q;
      o_emp_q  <= res_e_q[em_q];
      o_last_q <= em_last;
    end
  end

endmodule

[rtl/kmeans_2d_lloyd_pass.sv]
// Seed: written into its centroid slot. Point: the classifier sweeps one centroid
// per cycle through a subtract, square and compare pipe, then the accumulator adds it to
// its cluster after the queue. Last point: bit-serial division, one cluster at a time (an
// empty cluster skips the division), then CLUSTERS results at one per cycle while the
// output is ready; new items wait until the centroids are rewritten.
// Reset (async, active low) zeroes centroids, sums and counts and empties the queue.
module kmeans_2d_lloyd_pass #(
  parameter int CLUSTERS   = 4,
  parameter int COORD_BITS = 16,
  parameter int COUNT_BITS = 24
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  kml_in_if.sink    in_i,
  kml_out_if.source out_o
);

  localparam int IDX_W = $clog2(CLUSTERS);
  localparam int ENT_W = IDX_W + 2 * COORD_BITS + 1;

  logic                  push_valid, push_ready;
  logic [ENT_W-1:0]      push_data;
  logic                  pop_valid, pop_ready;
  logic [ENT_W-1:0]      pop_data;
  logic [IDX_W-1:0]      cen_idx;
  logic                  cen_we, upd_done;
  logic [COORD_BITS-1:0] cen_wx, cen_wy, cen_rx, cen_ry;

  kml_front #(
    .CLUSTERS   (CLUSTERS),
    .COORD_BITS (COORD_BITS),
    .IDX_W      (IDX_W),
    .ENT_W      (ENT_W)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data),
    .cen_idx_i    (cen_idx),
    .cen_we_i     (cen_we),
    .cen_x_i      (cen_wx),
    .cen_y_i      (cen_wy),
    .upd_done_i   (upd_done),
    .cen_x_o      (cen_rx),
    .cen_y_o      (cen_ry)
  );

  kml_queue #(
    .WIDTH (ENT_W),
    .DEPTH (kml_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  kml_back #(
    .CLUSTERS   (CLUSTERS),
    .COORD_BITS (COORD_BITS),
    .COUNT_BITS (COUNT_BITS),
    .IDX_W      (IDX_W),
    .ENT_W      (ENT_W)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .cen_idx_o   (cen_idx),
    .cen_we_o    (cen_we),
    .cen_x_o     (cen_wx),
    .cen_y_o     (cen_wy),
    .upd_done_o  (upd_done),
    .cen_x_i     (cen_rx),
    .cen_y_i     (cen_ry),
    .out_o       (out_o)
  );

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps

module testbench;

  localparam int NCLUST = 4;

  typedef struct packed {
    logic             kind;
    kml_pkg::coord_t  x;
    kml_pkg::coord_t  y;
    kml_pkg::slot_t   slot;
    logic             is_last;
  } request_t;

  typedef struct packed {
    kml_pkg::cidx_t   idx;
    kml_pkg::coord_t  mx;
    kml_pkg::coord_t  my;
    kml_pkg::count_t  cnt;
    logic             moved;
    logic             hollow;
    logic             tail;
  } cluster_result_t;

  class LloydScoreboard;
    kml_pkg::coord_t cx[NCLUST];
    kml_pkg::coord_t cy[NCLUST];
    logic [39:0]     sum_x[NCLUST];
    logic [39:0]     sum_y[NCLUST];
    kml_pkg::count_t members[NCLUST];
    cluster_result_t pending[$];
    int              errors;

    function new();
      errors = 0;
      foreach (cx[c]) begin
        cx[c] = '0;
        cy[c] = '0;
        sum_x[c] = '0;
        sum_y[c] = '0;
        members[c] = '0;
      end
    endfunction

    function logic [32:0] dist2(kml_pkg::coord_t px, kml_pkg::coord_t py, int c);
      logic [32:0] ax, ay;
      ax = (px >= cx[c]) ? 33'(px - cx[c]) : 33'(cx[c] - px);
      ay = (py >= cy[c]) ? 33'(py - cy[c]) : 33'(cy[c] - py);
      return ax * ax + ay * ay;
    endfunction

    function void note_request(request_t r);
      int              best;
      logic [32:0]     bd, d;
      kml_pkg::coord_t nx[NCLUST], ny[NCLUST];
      bit              hollow[NCLUST];
      bit              moved;
      cluster_result_t res;
      if (r.kind == kml_pkg::KIND_SEED) begin
        if (int'(r.slot) < NCLUST) begin
          cx[r.slot] = r.x;
          cy[r.slot] = r.y;
        end
        return;
      end
      // strict compare keeps the lower index on a tie
      best = 0;
      bd = dist2(r.x, r.y, 0);
      for (int c = 1; c < NCLUST; c++) begin
        d = dist2(r.x, r.y, c);
        if (d < bd) begin
          best = c;
          bd = d;
        end
      end
      if (members[best] != '1) begin
        members[best]++;
        sum_x[best] += 40'(r.x);
        sum_y[best] += 40'(r.y);
      end
      if (!r.is_last) return;
      moved = 1'b0;
      for (int c = 0; c < NCLUST; c++) begin
        hollow[c] = (members[c] == '0);
        if (hollow[c]) begin
          nx[c] = cx[c];
          ny[c] = cy[c];
        end else begin
          nx[c] = kml_pkg::coord_t'(sum_x[c] / 40'(members[c]));
          ny[c] = kml_pkg::coord_t'(sum_y[c] / 40'(members[c]));
          if (nx[c] != cx[c] || ny[c] != cy[c]) moved = 1'b1;
        end
      end
      for (int c = 0; c < NCLUST; c++) begin
        res.idx = kml_pkg::cidx_t'(c);
        res.mx = nx[c];
        res.my = ny[c];
        res.cnt = members[c];
        res.moved = moved;
        res.hollow = hollow[c];
        res.tail = (c == NCLUST - 1);
        pending.push_back(res);
        cx[c] = nx[c];
        cy[c] = ny[c];
        sum_x[c] = '0;
        sum_y[c] = '0;
        members[c] = '0;
      end
    endfunction

    function void check_result(cluster_result_t got);
      cluster_result_t want;
      if (pending.size() == 0) begin
        $error("unexpected result for cluster %0d", got.idx);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.idx != want.idx) begin
        $error("cluster_index: expected %0d, got %0d", want.idx, got.idx);
        errors++;
      end
      if (got.mx != want.mx) begin
        $error("mean_x: expected %h, got %h", want.mx, got.mx);
        errors++;
      end
      if (got.my != want.my) begin
        $error("mean_y: expected %h, got %h", want.my, got.my);
        errors++;
      end
      if (got.cnt != want.cnt) begin
        $error("member_count: expected %0d, got %0d", want.cnt, got.cnt);
        errors++;
      end
      if (got.moved != want.moved) begin
        $error("any_changed: expected %b, got %b", want.moved, got.moved);
        errors++;
      end
      if (got.hollow != want.hollow) begin
        $error("was_empty: expected %b, got %b", want.hollow, got.hollow);
        errors++;
      end
      if (got.tail != want.tail) begin
        $error("last_cluster: expected %b, got %b", want.tail, got.tail);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  kml_in_if  in_bus ();
  kml_out_if out_bus ();

  kmeans_2d_lloyd_pass u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  always #2 clk_i = ~clk_i;

  LloydScoreboard sb = new();
  int sent_count = 0;
  bit squeeze = 1'b0;
  bit squeeze_done = 1'b0;
  bit calm_pass = 1'b0;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 50);
  endfunction

  function automatic request_t seed_req(int slot, kml_pkg::coord_t x, kml_pkg::coord_t y,
                                        logic lst);
    request_t r;
    r.kind = kml_pkg::KIND_SEED;
    r.x = x;
    r.y = y;
    r.slot = kml_pkg::slot_t'(slot);
    r.is_last = lst;
    return r;
  endfunction

  function automatic request_t point_req(kml_pkg::coord_t x, kml_pkg::coord_t y, logic lst);
    request_t r;
    r.kind = kml_pkg::KIND_POINT;
    r.x = x;
    r.y = y;
    r.slot = kml_pkg::slot_t'($urandom_range(0, 3));
    r.is_last = lst;
    return r;
  endfunction

  function automatic kml_pkg::coord_t near(kml_pkg::coord_t c);
    int v;
    v = int'(c) + $urandom_range(0, 8191) - 4096;
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return kml_pkg::coord_t'(v);
  endfunction

  function automatic request_t random_point(logic lst);
    int r, c;
    r = $urandom_range(0, 99);
    c = $urandom_range(0, NCLUST - 1);
    if (r < 40) return point_req(kml_pkg::coord_t'($urandom), kml_pkg::coord_t'($urandom),
                                 lst);
    if (r < 80) return point_req(near(sb.cx[c]), near(sb.cy[c]), lst);
    if (r < 90) return point_req($urandom_range(0, 1) ? 16'hFFFF : 16'h0000,
                                 $urandom_range(0, 1) ? 16'hFFFF : 16'h0000, lst);
    // land exactly on a centroid to provoke ties
    return point_req(sb.cx[c], sb.cy[c], lst);
  endfunction

  // offer one request, hold it until taken, then sometimes idle a while
  task automatic push_request(request_t r);
    int gap;
    in_bus.valid      <= 1'b1;
    in_bus.kind       <= r.kind;
    in_bus.point_x    <= r.x;
    in_bus.point_y    <= r.y;
    in_bus.seed_slot  <= r.slot;
    in_bus.last_point <= r.is_last;
    @(posedge clk_i);
    while (!in_bus.ready) @(posedge clk_i);
    sb.note_request(r);
    sent_count++;
    gap = (squeeze || calm_pass) ? 0 : pick_gap();
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic run_directed();
    // centroids never seeded: all tie at zero, everything lands in cluster 0
    push_request(point_req(16'h1234, 16'h5678, 1'b0));
    push_request(point_req(16'hFFFF, 16'hFFFF, 1'b1));
    // seeds ignore their last flag
    push_request(seed_req(0, 16'h0000, 16'h0000, 1'b1));
    push_request(seed_req(1, 16'hFFFF, 16'h0000, 1'b0));
    push_request(seed_req(2, 16'h0000, 16'hFFFF, 1'b1));
    push_request(seed_req(3, 16'hFFFF, 16'hFFFF, 1'b0));
    push_request(point_req(16'h0000, 16'h0000, 1'b0));
    push_request(point_req(16'hFFFF, 16'hFFFF, 1'b0));
    push_request(point_req(16'hFFFF, 16'h0000, 1'b0));
    push_request(point_req(16'h0000, 16'hFFFF, 1'b0));
    push_request(point_req(16'h8000, 16'h8000, 1'b0));
    push_request(point_req(16'h7FFF, 16'h7FFF, 1'b1));
    // two equal centroids: lower index wins, the other stays empty, nothing moves
    push_request(seed_req(0, 16'h4000, 16'h4000, 1'b0));
    push_request(seed_req(1, 16'h4000, 16'h4000, 1'b0));
    push_request(point_req(16'h4000, 16'h4000, 1'b1));
    // small move with truncated mean
    push_request(point_req(16'h4000, 16'h4000, 1'b0));
    push_request(point_req(16'h4003, 16'h4001, 1'b1));
  endtask

  task automatic run_random();
    int n;
    while (sent_count < 520) begin
      calm_pass = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, NCLUST);
        repeat (n)
          push_request(seed_req($urandom_range(0, 3), kml_pkg::coord_t'($urandom),
                                kml_pkg::coord_t'($urandom), 1'($urandom)));
      end
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
      for (int i = 0; i < n; i++) begin
        // stray seed in the middle of a pass
        if ($urandom_range(0, 19) == 0)
          push_request(seed_req($urandom_range(0, 3), kml_pkg::coord_t'($urandom),
                                kml_pkg::coord_t'($urandom), 1'($urandom)));
        push_request(random_point(i == n - 1));
      end
    end
    calm_pass = 1'b0;
  endtask

  initial begin
    in_bus.valid      = 1'b0;
    in_bus.kind       = kml_pkg::KIND_SEED;
    in_bus.point_x    = '0;
    in_bus.point_y    = '0;
    in_bus.seed_slot  = '0;
    in_bus.last_point = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();
    run_random();
    in_bus.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("** kmeans_2d_lloyd_pass: PASSED **");
    end else begin
      $display("** kmeans_2d_lloyd_pass: FAILED **");
    end
    $finish;
  end

  initial begin : result_sink
    int stall_left, calm_left, hold_left, r;
    stall_left = 0;
    calm_left = 0;
    hold_left = 0;
    out_bus.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_bus.valid && out_bus.ready)
        sb.check_result(cluster_result_t'{out_bus.cluster_index, out_bus.mean_x,
                                          out_bus.mean_y, out_bus.member_count,
                                          out_bus.any_changed, out_bus.was_empty,
                                          out_bus.last_cluster});
      // one long hold-off while the sender keeps pushing, to back up the input
      if (!squeeze_done && sent_count >= 150) begin
        squeeze = 1'b1;
        squeeze_done = 1'b1;
        hold_left = 600;
      end
      if (hold_left > 0) begin
        hold_left--;
        if (hold_left == 0) squeeze = 1'b0;
        out_bus.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
        if (calm_left > 0) begin
          calm_left--;
        end else begin
          r = $urandom_range(0, 99);
          if (r < 15) stall_left = $urandom_range(1, 3);
          else if (r < 17) stall_left = $urandom_range(20, 60);
          else if (r < 19) calm_left = $urandom_range(30, 120);
        end
      end
    end
  end

  initial begin
    #10_000_000;
    $display("** kmeans_2d_lloyd_pass: FAILED **");
    $finish;
  end

endmodule

[files.f]
rtl/kml_pkg.sv
rtl/kml_if.sv
rtl/kml_queue.sv
rtl/kml_front.sv
rtl/kml_back.sv
rtl/kmeans_2d_lloyd_pass.sv
tb/testbench.sv
